// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define UDRS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define UDRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define UDRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/udrs_pkg.sv -----
// Shared types, constants and helpers of the uniform dice rejection sampler.
package udrs_pkg;

  localparam int BASE_STREAM_BYTES = 64;
  localparam int MAX_DOUBLINGS     = 3;
  localparam int BUDGET_BYTES      = BASE_STREAM_BYTES << MAX_DOUBLINGS;
  localparam int CNT_W             = $clog2(BUDGET_BYTES + 1);

  localparam int VAL_W   = 31;
  localparam int ACC_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int BITS_W  = 5;
  localparam int GROUP_W = 3;
  localparam int SHIFT_W = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    REG_DIE_SIDES   = 2'd0,
    REG_ROLL_COUNT  = 2'd1,
    REG_OUTPUT_ROOM = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_ROLL   = 2'd0,
    STATUS_ROOM   = 2'd1,
    STATUS_BUDGET = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   roll_value;
    logic               last;
  } result_t;

  // Results of one accepted item: how many, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [VAL_W-1:0]  die_sides;
    logic [VAL_W-1:0]  roll_count;
    logic [VAL_W-1:0]  output_room;
    logic [BITS_W-1:0] sides_bits;
  } cfg_t;

  // Bit length of sides minus one, at least one bit.
  function automatic logic [BITS_W-1:0] roll_bits(input logic [VAL_W-1:0] sides);
    logic [VAL_W-1:0]  v;
    logic [BITS_W-1:0] n;
    v = sides - VAL_W'(1);
    n = BITS_W'(1);
    for (int i = 0; i < VAL_W; i++) begin
      if (v[i]) n = BITS_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// ----- rtl/udrs_regs.sv -----
// Configuration register file behind the APB-style port.
module udrs_regs import udrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.die_sides   <= VAL_W'(2);
      cfg.roll_count  <= VAL_W'(1);
      cfg.output_room <= {VAL_W{1'b1}};
      cfg.sides_bits  <= BITS_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_DIE_SIDES: begin
          cfg.die_sides  <= pwdata[VAL_W-1:0];
          // The roll width is worked out here so a run start needs no search.
          cfg.sides_bits <= roll_bits(pwdata[VAL_W-1:0]);
        end
        REG_ROLL_COUNT:  cfg.roll_count  <= pwdata[VAL_W-1:0];
        REG_OUTPUT_ROOM: cfg.output_room <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIE_SIDES:   prdata = {1'b0, cfg.die_sides};
      REG_ROLL_COUNT:  prdata = {1'b0, cfg.roll_count};
      REG_OUTPUT_ROOM: prdata = {1'b0, cfg.output_room};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/udrs_core.sv -----
// Run state and single-pass sampling logic for one command per cycle while fire is high.
`include "assert_macros.svh"

module udrs_core import udrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              command,
  input  logic [BYTE_W-1:0] stream_byte,
  input  cfg_t              cfg,
  output push_t             push
);

  localparam int SUM_W = CNT_W + 1;

  logic               run_active,        run_active_next;
  logic [ACC_W-1:0]   group_accumulator, group_accumulator_next;
  logic [1:0]         byte_in_group,     byte_in_group_next;
  logic [GROUP_W-1:0] group_bytes,       group_bytes_next;
  logic [SHIFT_W-1:0] drop_shift,        drop_shift_next;
  logic [CNT_W-1:0]   bytes_consumed,    bytes_consumed_next;
  logic [VAL_W-1:0]   rolls_done,        rolls_done_next;

  logic [BITS_W:0]    bits_round;
  logic [GROUP_W-1:0] start_group;
  logic [BITS_W:0]    start_drop;
  logic [ACC_W-1:0]   acc_shift;
  logic [GROUP_W-1:0] count_in_group;
  logic [ACC_W-1:0]   cand;
  logic [VAL_W-1:0]   rolls_inc;
  logic [SUM_W-1:0]   need_start;
  logic [SUM_W-1:0]   need_byte;

  assign bits_round  = {1'b0, cfg.sides_bits} + (BITS_W+1)'(7);
  assign start_group = bits_round[BITS_W:3];
  assign start_drop  = {start_group, 3'b000} - {1'b0, cfg.sides_bits};
  assign need_start  = SUM_W'(start_group);

  assign acc_shift      = {group_accumulator[ACC_W-BYTE_W-1:0], stream_byte};
  assign count_in_group = GROUP_W'(byte_in_group) + GROUP_W'(1);
  assign cand           = acc_shift >> drop_shift;
  assign rolls_inc      = rolls_done + VAL_W'(1);
  assign need_byte      = SUM_W'(bytes_consumed) + SUM_W'(1) + SUM_W'(group_bytes);

  always_comb begin
    run_active_next        = run_active;
    group_accumulator_next = group_accumulator;
    byte_in_group_next     = byte_in_group;
    group_bytes_next       = group_bytes;
    drop_shift_next        = drop_shift;
    bytes_consumed_next    = bytes_consumed;
    rolls_done_next        = rolls_done;

    push.count             = 2'd0;
    push.first.status      = STATUS_ROLL;
    push.first.roll_value  = '0;
    push.first.last        = 1'b0;
    push.second.status     = STATUS_BUDGET;
    push.second.roll_value = '0;
    push.second.last       = 1'b1;

    if (fire) begin
      if (command == CMD_START) begin
        group_bytes_next       = start_group;
        drop_shift_next        = start_drop[SHIFT_W-1:0];
        group_accumulator_next = '0;
        byte_in_group_next     = '0;
        bytes_consumed_next    = '0;
        rolls_done_next        = '0;
        run_active_next        = 1'b0;
        if (cfg.output_room < cfg.roll_count) begin
          push.count        = 2'd1;
          push.first.status = STATUS_ROOM;
          push.first.last   = 1'b1;
        end else if (cfg.roll_count != '0) begin
          if (need_start > SUM_W'(BUDGET_BYTES)) begin
            push.count        = 2'd1;
            push.first.status = STATUS_BUDGET;
            push.first.last   = 1'b1;
          end else begin
            run_active_next = 1'b1;
          end
        end
      end else if (run_active) begin
        bytes_consumed_next = bytes_consumed + CNT_W'(1);
        if (count_in_group < group_bytes) begin
          group_accumulator_next = acc_shift;
          byte_in_group_next     = count_in_group[1:0];
        end else begin
          group_accumulator_next = '0;
          byte_in_group_next     = '0;
          if (cand < {1'b0, cfg.die_sides}) begin
            rolls_done_next       = rolls_inc;
            push.count            = 2'd1;
            push.first.roll_value = cand[VAL_W-1:0];
            if (rolls_inc >= cfg.roll_count) begin
              run_active_next = 1'b0;
              push.first.last = 1'b1;
            end
          end
          // The budget check only runs if the group did not end the run.
          if (!push.first.last && need_byte > SUM_W'(BUDGET_BYTES)) begin
            run_active_next = 1'b0;
            if (push.count == 2'd1) begin
              push.count = 2'd2;
            end else begin
              push.count        = 2'd1;
              push.first.status = STATUS_BUDGET;
              push.first.last   = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active        <= 1'b0;
      group_accumulator <= '0;
      byte_in_group     <= '0;
      group_bytes       <= GROUP_W'(1);
      drop_shift        <= '0;
      bytes_consumed    <= '0;
      rolls_done        <= '0;
    end else begin
      run_active        <= run_active_next;
      group_accumulator <= group_accumulator_next;
      byte_in_group     <= byte_in_group_next;
      group_bytes       <= group_bytes_next;
      drop_shift        <= drop_shift_next;
      bytes_consumed    <= bytes_consumed_next;
      rolls_done        <= rolls_done_next;
    end
  end

  `UDRS_ASSERT_IMPLY(a_start_single, clk, rst, fire && command == CMD_START, push.count <= 2'd1, "start gave two results")
  `UDRS_ASSERT_IMPLY(a_roll_range, clk, rst, push.count != 2'd0 && push.first.status == STATUS_ROLL, push.first.roll_value < cfg.die_sides, "roll not below die_sides")
  `UDRS_ASSERT_ALWAYS(a_group_pos, clk, rst, GROUP_W'(byte_in_group) < group_bytes, "byte position past group size")
  `UDRS_ASSERT_IMPLY(a_pair_order, clk, rst, push.count == 2'd2, push.first.status == STATUS_ROLL && !push.first.last, "bad result pair")

endmodule

// ----- rtl/udrs_out_queue.sv -----
// Small result queue that decouples the sampler from the receiver.
`include "assert_macros.svh"

module udrs_out_queue import udrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head_item
);

  localparam int CNT_QW = QUEUE_AW + 1;

  result_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head, tail;
  logic [CNT_QW-1:0]   count, count_next;
  logic                pop;
  logic [QUEUE_AW-1:0] tail_plus;

  assign out_valid = count != '0;
  assign pop       = out_valid & out_ready;
  assign head_item = entries[head];
  // A new item may bring two results, so two free slots are needed.
  assign space     = count <= CNT_QW'(QUEUE_DEPTH - 2);
  assign tail_plus = tail + QUEUE_AW'(1);
  assign count_next = count + CNT_QW'(push.count) - CNT_QW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[tail] <= push.first;
    if (push.count == 2'd2) entries[tail_plus] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QUEUE_AW'(pop);
      tail  <= tail + QUEUE_AW'(push.count);
      count <= count_next;
    end
  end

  `UDRS_ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNT_QW'(QUEUE_DEPTH), "queue count overflow")
  `UDRS_ASSERT_IMPLY(a_push_fits, clk, rst, push.count != 2'd0, CNT_QW'(push.count) + count <= CNT_QW'(QUEUE_DEPTH), "push into full queue")
  `UDRS_ASSERT_NEXT(a_idle_empty, clk, rst, count == '0 && push.count == 2'd0, count == '0, "queue filled without push")

endmodule

// ----- rtl/uniform_dice_rejection_sampler.sv -----
// Top level of the uniform dice rejection sampler.
//
// Input channel (in_valid/in_ready): one command per transfer. Command 0
// starts a run with the current registers; command 1 delivers the next
// random stream byte. Output channel (out_valid/out_ready): one result per
// transfer with status, roll_value and last; last marks the end of a run.
// Registers are to be written over the APB-style port only while the
// block is idle; the block itself does not enforce this.
// Latency: results of an input transfer are offered from the next cycle on.
// Throughput: one input transfer per cycle while in_ready is high; the
// per-byte work is two shifts, four compares and counter updates between
// the input and the result queue. A byte that yields a roll and a budget
// error puts two results in the four-entry result queue; in_ready is low
// whenever fewer than two entries are free, so a stalled receiver holds
// back the input once three results are waiting.
//
// Reset clears the run state and the queue and loads the register defaults.
module uniform_dice_rejection_sampler import udrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [BYTE_W-1:0] stream_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [VAL_W-1:0]  roll_value,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  push_t   push;
  result_t head_item;
  logic    fire;

  assign fire = in_valid & in_ready;

  udrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  udrs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .command     (command),
    .stream_byte (stream_byte),
    .cfg         (cfg),
    .push        (push)
  );

  udrs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_item (head_item)
  );

  assign status     = head_item.status;
  assign roll_value = head_item.roll_value;
  assign last       = head_item.last;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the uniform dice rejection sampler.
`timescale 1ns / 100ps

module tb_top import udrs_pkg::*; ;

  localparam logic [VAL_W-1:0] FULL31   = '1;
  localparam int               SHOW_MAX = 200;
  localparam int               N_ITEMS  = 1600;

  // Predicts the results of every accepted transfer and checks the results
  // that leave the block, oldest expectation first.
  class dice_scoreboard;
    logic [VAL_W-1:0] sides, count, room;
    bit               active;
    logic [ACC_W-1:0] acc;
    int unsigned      in_group, group_len, shift, consumed;
    logic [VAL_W-1:0] rolls;
    result_t          roll_q[$];
    int unsigned      errors, n_rolls, n_room, n_budget;

    function new();
      sides     = VAL_W'(2);
      count     = VAL_W'(1);
      room      = FULL31;
      active    = 1'b0;
      acc       = '0;
      in_group  = 0;
      group_len = 1;
      shift     = 0;
      consumed  = 0;
      rolls     = '0;
      errors    = 0;
      n_rolls   = 0;
      n_room    = 0;
      n_budget  = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [VAL_W-1:0] v);
      case (idx)
        REG_DIE_SIDES:   sides = v;
        REG_ROLL_COUNT:  count = v;
        REG_OUTPUT_ROOM: room  = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return roll_q.size();
    endfunction

    function void expect_result(status_t st, logic [VAL_W-1:0] v, logic l);
      result_t r;
      r.status     = st;
      r.roll_value = v;
      r.last       = l;
      roll_q.push_back(r);
    endfunction

    // The run ends when the next group would overrun the stream budget.
    function void budget_check();
      if (active && (consumed + group_len > BUDGET_BYTES)) begin
        active = 1'b0;
        expect_result(STATUS_BUDGET, '0, 1'b1);
      end
    endfunction

    function void note_input(logic cmd, logic [BYTE_W-1:0] b);
      int unsigned      bits;
      logic [VAL_W-1:0] span;
      logic [ACC_W-1:0] cand;
      if (cmd == CMD_START) begin
        span = sides - VAL_W'(1);
        bits = 0;
        while (span != 0) begin
          bits++;
          span = span >> 1;
        end
        if (bits == 0) bits = 1;
        group_len = (bits + 7) / 8;
        shift     = group_len * 8 - bits;
        acc       = '0;
        in_group  = 0;
        consumed  = 0;
        rolls     = '0;
        active    = 1'b0;
        if (room < count) begin
          expect_result(STATUS_ROOM, '0, 1'b1);
          return;
        end
        if (count == 0) return;
        active = 1'b1;
        budget_check();
        return;
      end
      if (!active) return;
      acc = (acc << 8) | ACC_W'(b);
      consumed++;
      in_group++;
      if (in_group < group_len) return;
      cand     = acc >> shift;
      acc      = '0;
      in_group = 0;
      if (cand < {1'b0, sides}) begin
        rolls = rolls + VAL_W'(1);
        if (rolls >= count) begin
          active = 1'b0;
          expect_result(STATUS_ROLL, cand[VAL_W-1:0], 1'b1);
          return;
        end
        expect_result(STATUS_ROLL, cand[VAL_W-1:0], 1'b0);
      end
      budget_check();
    endfunction

    // Counts a failure; only the first SHOW_MAX (200) are printed.
    function bit note_error();
      errors++;
      return errors <= SHOW_MAX;
    endfunction

    function void check_result(logic [1:0] st, logic [VAL_W-1:0] v, logic l);
      result_t want;
      if (roll_q.size() == 0) begin
        if (note_error())
          $display("%0t unexpected result: status %0d roll_value %0d last %0b",
                   $time, st, v, l);
        return;
      end
      want = roll_q.pop_front();
      if (st != want.status && note_error())
        $display("%0t status mismatch: expected %0d actual %0d", $time, want.status, st);
      if (v != want.roll_value && note_error())
        $display("%0t roll_value mismatch: expected %0d actual %0d",
                 $time, want.roll_value, v);
      if (l != want.last && note_error())
        $display("%0t last mismatch: expected %0b actual %0b", $time, want.last, l);
      case (want.status)
        STATUS_ROLL:   n_rolls++;
        STATUS_ROOM:   n_room++;
        STATUS_BUDGET: n_budget++;
        default: ;
      endcase
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              command     = CMD_START;
  logic [BYTE_W-1:0] stream_byte = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [1:0]        status;
  logic [VAL_W-1:0]  roll_value;
  logic              last;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dice_scoreboard sb = new();

  int unsigned send_idle  = 10;
  int unsigned recv_idle  = 72;
  int unsigned n_items    = 0;
  int unsigned n_settings = 0;

  uniform_dice_rejection_sampler u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .roll_value  (roll_value),
    .last        (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check every transfer and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(status, roll_value, last);
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
    bit counts;
    if (n_items < N_ITEMS / 3) begin
      send_idle = 10;
      recv_idle = 72;
    end else if (n_items < 2 * N_ITEMS / 3) begin
      send_idle = 72;
      recv_idle = 10;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    // Bytes that arrive with no run active are dropped and not counted.
    counts = (cmd == CMD_START) || sb.active;
    sb.note_input(cmd, b);
    if (counts) n_items++;
  endtask

  // Wait until the block has drained and gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [VAL_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= {1'($urandom_range(0, 1)), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    // The bus goes idle before the next access.
    @(posedge clk);
  endtask

  // One register setting, then one to max_runs runs, each fed until it ends
  // or the item budget of the whole test is used up.
  task automatic random_phase(input logic [VAL_W-1:0] s, input logic [VAL_W-1:0] c,
                              input logic [VAL_W-1:0] r, input int unsigned max_runs);
    int unsigned runs;
    settle();
    write_reg(REG_DIE_SIDES, s);
    write_reg(REG_ROLL_COUNT, c);
    write_reg(REG_OUTPUT_ROOM, r);
    n_settings++;
    runs = $urandom_range(1, max_runs);
    repeat (runs) begin
      if (n_items >= N_ITEMS) break;
      send_item(CMD_START, rand_byte());
      while (sb.active && n_items < N_ITEMS) begin
        if ($urandom_range(0, 99) < 2) send_item(CMD_START, rand_byte());
        else send_item(CMD_BYTE, rand_byte());
      end
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, rand_byte());
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_sides();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0:       return '0;
          1:       return VAL_W'(1);
          2:       return VAL_W'(2);
          3:       return FULL31;
          4:       return VAL_W'(256);
          5:       return VAL_W'(257);
          6:       return VAL_W'(65537);
          default: return VAL_W'(24'hFFFFFF) + VAL_W'(2);
        endcase
      end
      1, 2, 3, 4, 5: return VAL_W'($urandom_range(2, 300));
      6, 7:          return VAL_W'($urandom_range(2, 70000));
      8:             return VAL_W'($urandom);
      default:       return VAL_W'(1) << $urandom_range(1, 30);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return FULL31;
      2:       return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_room(input logic [VAL_W-1:0] c);
    case ($urandom_range(0, 9))
      0:       return (c == 0) ? '0 : VAL_W'($urandom_range(0, 1000)) % c;
      1:       return c;
      2:       return VAL_W'($urandom);
      default: return FULL31;
    endcase
  endfunction

  initial begin
    logic [VAL_W-1:0] c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the register defaults.
    send_item(CMD_BYTE, 8'h5A);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    // A start in the middle of a run throws the run away.
    settle();
    write_reg(REG_ROLL_COUNT, VAL_W'(3));
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h80);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_BYTE, 8'hFF);
    settle();
    write_reg(REG_ROLL_COUNT, '0);
    send_item(CMD_START, 8'h3C);
    settle();
    write_reg(REG_OUTPUT_ROOM, '0);
    write_reg(REG_ROLL_COUNT, VAL_W'(1));
    send_item(CMD_START, 8'h00);
    // A one-face die takes only a zero roll.
    settle();
    write_reg(REG_OUTPUT_ROOM, FULL31);
    write_reg(REG_DIE_SIDES, VAL_W'(1));
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h80);
    send_item(CMD_BYTE, 8'h7F);
    settle();
    write_reg(REG_DIE_SIDES, FULL31);
    send_item(CMD_START, 8'h00);
    repeat (4) send_item(CMD_BYTE, 8'hFF);
    repeat (3) send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFD);

    // Fixed settings: the last byte of a one-byte die gives a roll and the
    // budget error together; a zero-face die never accepts.
    random_phase(VAL_W'(256), FULL31, FULL31, 1);
    random_phase('0, VAL_W'(5), FULL31, 1);
    random_phase(FULL31, VAL_W'(5), FULL31, 1);
    random_phase(VAL_W'(100), VAL_W'(7), VAL_W'(7), 1);

    while (n_items < N_ITEMS) begin
      c = pick_count();
      random_phase(pick_sides(), c, pick_room(c), 4);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d input transfers over %0d register settings.", n_items, n_settings);
    $display("Checked %0d rolls, %0d capacity errors and %0d budget errors.",
             sb.n_rolls, sb.n_room, sb.n_budget);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS uniform_dice_rejection_sampler");
    end else begin
      $display("FAIL uniform_dice_rejection_sampler");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", sb.pending());
    $display("FAIL uniform_dice_rejection_sampler");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/udrs_pkg.sv
rtl/udrs_regs.sv
rtl/udrs_core.sv
rtl/udrs_out_queue.sv
rtl/uniform_dice_rejection_sampler.sv
tb/sv/tb_top.sv
